// ===== rtl/sbmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbmm_pkg
// Shared types and constants for the sort-between-min-and-max block.
// ----------------------------------------------------------------------------
package sbmm_pkg;

    localparam int DATA_W               = 16;
    localparam int DEFAULT_MAX_ELEMENTS = 32;

    // sequencer to tracker control
    typedef struct packed {
        logic load;   // item accepted
        logic clear;  // set fully emitted
    } sbmm_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/sbmm_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbmm_tracker
// Element count and first-minimum / first-maximum position tracking.
// ----------------------------------------------------------------------------
module sbmm_tracker
    import sbmm_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS,
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
    localparam int POS_W = $clog2(MAX_ELEMENTS)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire sbmm_ctrl_t               ctrl,
    input  wire logic signed [DATA_W-1:0] value,
    output logic             [CNT_W-1:0]  count,
    output logic             [POS_W-1:0]  least_pos,
    output logic             [POS_W-1:0]  greatest_pos
);

    logic        [CNT_W-1:0]  count_reg;
    logic signed [DATA_W-1:0] least_reg;
    logic signed [DATA_W-1:0] greatest_reg;
    logic        [POS_W-1:0]  least_pos_reg;
    logic        [POS_W-1:0]  greatest_pos_reg;
    logic        [POS_W-1:0]  pos;
    logic                     has_room;

    assign pos      = count_reg[POS_W-1:0];
    assign has_room = count_reg < CNT_W'(MAX_ELEMENTS);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            count_reg        <= '0;
            least_reg        <= '0;
            greatest_reg     <= '0;
            least_pos_reg    <= '0;
            greatest_pos_reg <= '0;
        end else if (ctrl.load && has_room) begin
            count_reg <= count_reg + CNT_W'(1);
            if (count_reg == '0) begin
                least_reg        <= value;
                greatest_reg     <= value;
                least_pos_reg    <= '0;
                greatest_pos_reg <= '0;
            end else begin
                if (value < least_reg) begin
                    least_reg     <= value;
                    least_pos_reg <= pos;
                end
                if (value > greatest_reg) begin
                    greatest_reg     <= value;
                    greatest_pos_reg <= pos;
                end
            end
        end
    end

    assign count        = count_reg;
    assign least_pos    = least_pos_reg;
    assign greatest_pos = greatest_pos_reg;

endmodule
`default_nettype wire

// ===== rtl/sbmm_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbmm_seq
// Element memory with load, in-place insertion sort and emit sequencer.
// ----------------------------------------------------------------------------
module sbmm_seq
    import sbmm_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS,
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
    localparam int POS_W = $clog2(MAX_ELEMENTS)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] in_value,
    input  wire logic                     in_last,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed      [DATA_W-1:0] out_value,
    output logic                          out_last,
    input  wire logic        [CNT_W-1:0]  count,
    input  wire logic        [POS_W-1:0]  least_pos,
    input  wire logic        [POS_W-1:0]  greatest_pos,
    output sbmm_ctrl_t                    ctrl
);

    localparam logic [3:0] ST_LOAD      = 4'd0;
    localparam logic [3:0] ST_SETUP     = 4'd1;
    localparam logic [3:0] ST_OUTER     = 4'd2;
    localparam logic [3:0] ST_KEY       = 4'd3;
    localparam logic [3:0] ST_CMP       = 4'd4;
    localparam logic [3:0] ST_INS       = 4'd5;
    localparam logic [3:0] ST_EMIT_RD   = 4'd6;
    localparam logic [3:0] ST_EMIT_LD   = 4'd7;
    localparam logic [3:0] ST_EMIT_HOLD = 4'd8;

    logic        [3:0]        state_reg, state_next;
    logic        [POS_W-1:0]  lo_reg, lo_next;
    logic        [POS_W-1:0]  hi_reg, hi_next;
    logic        [POS_W-1:0]  i_reg, i_next;
    logic        [POS_W-1:0]  j_reg, j_next;
    logic        [POS_W-1:0]  k_reg, k_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_last_reg, out_last_next;

    logic        [DATA_W-1:0] mem [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic        [POS_W-1:0]  rd_addr;
    logic        [POS_W-1:0]  wr_addr;
    logic        [DATA_W-1:0] wr_data;
    logic                     wr_en;

    logic                     accept;
    logic        [POS_W-1:0]  pos_min, pos_max;

    assign accept  = in_valid && in_ready;
    assign pos_min = (least_pos < greatest_pos) ? least_pos : greatest_pos;
    assign pos_max = (least_pos < greatest_pos) ? greatest_pos : least_pos;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= $signed(mem[rd_addr]);
    end

    always_comb begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        key_next       = key_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        rd_addr        = '0;
        wr_addr        = '0;
        wr_data        = '0;
        wr_en          = 1'b0;
        in_ready       = 1'b0;
        ctrl           = '0;

        unique case (state_reg)
            ST_LOAD: begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
                wr_addr   = count[POS_W-1:0];
                wr_data   = in_value;
                wr_en     = accept && (count < CNT_W'(MAX_ELEMENTS));
                if (accept && in_last) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                lo_next = pos_min;
                hi_next = pos_max;
                i_next  = pos_min + POS_W'(2);
                k_next  = '0;
                if ({1'b0, pos_max} > ({1'b0, pos_min} + (POS_W+1)'(1))) begin
                    state_next = ST_OUTER;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_OUTER: begin
                rd_addr = i_reg;
                if (i_reg < hi_reg) begin
                    state_next = ST_KEY;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_KEY: begin
                key_next   = rd_data_reg;
                j_next     = i_reg;
                rd_addr    = i_reg - POS_W'(1);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                if (rd_data_reg > key_reg) begin
                    wr_data = rd_data_reg;
                    j_next  = j_reg - POS_W'(1);
                    rd_addr = j_reg - POS_W'(2);
                    if ({1'b0, j_reg} > ({1'b0, lo_reg} + (POS_W+1)'(2))) begin
                        state_next = ST_CMP;
                    end else begin
                        state_next = ST_INS;
                    end
                end else begin
                    wr_data    = key_reg;
                    i_next     = i_reg + POS_W'(1);
                    state_next = ST_OUTER;
                end
            end
            ST_INS: begin
                wr_en      = 1'b1;
                wr_addr    = j_reg;
                wr_data    = key_reg;
                i_next     = i_reg + POS_W'(1);
                state_next = ST_OUTER;
            end
            ST_EMIT_RD: begin
                rd_addr    = k_reg;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                out_value_next = rd_data_reg;
                out_valid_next = 1'b1;
                out_last_next  = (CNT_W'(k_reg) + CNT_W'(1)) == count;
                state_next     = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                if (out_ready) begin
                    out_valid_next = 1'b0;
                    if (out_last_reg) begin
                        ctrl.clear = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + POS_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        key_reg       <= key_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/sort_between_min_and_max.sv =====
`default_nettype none
// Loading: one item per cycle, ready held high until the item marked last.
// Sort: setup; each inner element but the first takes outer, key and compare steps
// plus one per shift, then exit; the single-port-write element memory sets this pace.
// Emit: read, load and hold per result, the hold waiting out stalls; ready is low meanwhile.
// Reset (aresetn low, synchronous) clears the sequencer, count and trackers.
// ----------------------------------------------------------------------------
// sort_between_min_and_max
// Loads a signed set, sorts the elements strictly between the first minimum
// and first maximum positions, and streams the whole set back out.
// ----------------------------------------------------------------------------
module sort_between_min_and_max
    import sbmm_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample_value
    input  wire logic        s_tlast,   // last_item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [15:0] out_value
    output logic             m_tlast    // out_last
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int POS_W = $clog2(MAX_ELEMENTS);

    sbmm_ctrl_t               ctrl;
    logic        [CNT_W-1:0]  count;
    logic        [POS_W-1:0]  least_pos;
    logic        [POS_W-1:0]  greatest_pos;
    logic signed [DATA_W-1:0] out_value;

    sbmm_tracker #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .value        ($signed(s_tdata)),
        .count        (count),
        .least_pos    (least_pos),
        .greatest_pos (greatest_pos)
    );

    sbmm_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_value     ($signed(s_tdata)),
        .in_last      (s_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_value    (out_value),
        .out_last     (m_tlast),
        .count        (count),
        .least_pos    (least_pos),
        .greatest_pos (greatest_pos),
        .ctrl         (ctrl)
    );

    assign m_tdata = out_value;

endmodule
`default_nettype wire

// ===== tb/sbmm_checker.sv =====
// ----------------------------------------------------------------------------
// sbmm_checker
// Watches both stream channels of the sort-between-min-and-max block. It
// rebuilds each set from the accepted input items, tracks the first minimum
// and first maximum, and sorts the elements between them. Each accepted
// output item is then compared against the oldest expected element.
// ----------------------------------------------------------------------------
module sbmm_checker
    import sbmm_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,     // [15:0] sample_value
    input  logic              s_tlast,     // last_item
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,     // [15:0] out_value
    input  logic              m_tlast,     // out_last
    output int                mismatches,
    output int                pending,
    output int                results_seen
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } set_elem_t;

    set_elem_t                expected_elems[$];
    logic signed [DATA_W-1:0] held[MAX_ELEMENTS];
    int                       held_count;
    logic signed [DATA_W-1:0] least_v;
    logic signed [DATA_W-1:0] greatest_v;
    int                       least_pos;
    int                       greatest_pos;
    int                       errs;
    int                       seen;

    function automatic void clear_tracking();
        held_count   = 0;
        least_v      = '0;
        greatest_v   = '0;
        least_pos    = 0;
        greatest_pos = 0;
    endfunction

    // ascending sort of held[first..stop-1]
    function automatic void sort_inner(int first, int stop);
        logic signed [DATA_W-1:0] key;
        int j;
        for (int i = first + 1; i < stop; i++) begin
            key = held[i];
            j = i;
            while (j > first && held[j-1] > key) begin
                held[j] = held[j-1];
                j--;
            end
            held[j] = key;
        end
    endfunction

    function automatic void take_sample(logic [DATA_W-1:0] raw, logic closes);
        logic signed [DATA_W-1:0] v;
        int lo;
        int hi;
        set_elem_t e;
        v = $signed(raw);
        if (held_count < MAX_ELEMENTS) begin
            held[held_count] = v;
            if (held_count == 0) begin
                least_v      = v;
                greatest_v   = v;
                least_pos    = 0;
                greatest_pos = 0;
            end else begin
                if (v < least_v) begin
                    least_v   = v;
                    least_pos = held_count;
                end
                if (v > greatest_v) begin
                    greatest_v   = v;
                    greatest_pos = held_count;
                end
            end
            held_count++;
        end
        if (closes) begin
            lo = (least_pos < greatest_pos) ? least_pos : greatest_pos;
            hi = (least_pos < greatest_pos) ? greatest_pos : least_pos;
            if (hi > lo + 1 && hi <= held_count)
                sort_inner(lo + 1, hi);
            for (int k = 0; k < held_count; k++) begin
                e.value = held[k];
                e.last  = (k == held_count - 1);
                expected_elems = {expected_elems, e};
            end
            clear_tracking();
        end
    endfunction

    function automatic void log_mismatch(string what, set_elem_t exp_e);
        errs++;
        if (errs <= 10)
            $display("[%0t] mismatch (%s): expected value %h last %b, got value %h last %b",
                     $realtime, what, exp_e.value, exp_e.last, m_tdata, m_tlast);
    endfunction

    always @(posedge aclk) begin
        set_elem_t exp_e;
        if (!aresetn) begin
            clear_tracking();
            expected_elems.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen++;
                if (expected_elems.size() == 0) begin
                    exp_e = '0;
                    log_mismatch("unexpected item", exp_e);
                end else begin
                    exp_e = expected_elems.pop_front();
                    if (exp_e.value !== m_tdata || exp_e.last !== m_tlast)
                        log_mismatch("wrong field", exp_e);
                end
            end
            if (s_tvalid && s_tready)
                take_sample(s_tdata, s_tlast);
        end
        mismatches   <= errs;
        pending      <= expected_elems.size();
        results_seen <= seen;
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the sort-between-min-and-max block: a few hand-built sets
// covering the min/max ordering cases, then random sets of varied length,
// some running past the store capacity, with random gaps on the input side
// and random stalls on the output side. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb_top
    import sbmm_pkg::*;
();

    localparam int NUM_ITEMS = 350;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [15:0] sample_value
    logic        s_tlast  = 1'b0;  // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [15:0] out_value
    logic        m_tlast;          // out_last

    int          mismatches;
    int          pending;
    int          results_seen;

    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          items_sent = 0;
    int          sets_sent = 0;
    int          overflow_sets = 0;
    logic [15:0] set_buf[$];

    always #2 aclk = ~aclk;

    sort_between_min_and_max dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sbmm_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    task automatic send_item(input logic [15:0] v, input logic closes);
        int gap;
        gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= v;
        s_tlast  <= closes;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_buf();
        for (int i = 0; i < set_buf.size(); i++)
            send_item(set_buf[i], i == set_buf.size() - 1);
        if (set_buf.size() > DEFAULT_MAX_ELEMENTS)
            overflow_sets++;
        sets_sent++;
    endtask

    function automatic logic [15:0] make_value(int style);
        case (style)
            0: begin
                return 16'($urandom_range(0, 65535));
            end
            1: begin
                return 16'($urandom_range(0, 15) - 8);
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    4: return 16'h0001;
                    default: return 16'($urandom_range(0, 65535));
                endcase
            end
        endcase
    endfunction

    initial begin
        int len;
        int style;
        int pick;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single element
        set_buf = '{16'h8000};
        send_buf();
        // min and max adjacent
        set_buf = '{16'h7fff, 16'h8000};
        send_buf();
        // max first, min last, repeated max is not taken
        set_buf = '{16'd50, 16'd7, 16'd50, 16'hffff, 16'd3, 16'hfff7};
        send_buf();
        // min first, max last, repeated min is not taken
        set_buf = '{16'hfffb, 16'd10, 16'd2, 16'hfffb, 16'd8, 16'd20};
        send_buf();
        // all equal
        set_buf = '{16'h1234, 16'h1234, 16'h1234};
        send_buf();
        // min and max both inside, with wide-range content
        set_buf = '{16'd0, 16'h7fff, 16'h0100, 16'hff00, 16'h0010, 16'h8000, 16'd1};
        send_buf();

        while (items_sent < NUM_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            pick  = $urandom_range(0, 19);
            if (pick < 13)
                len = $urandom_range(1, 10);
            else if (pick < 18)
                len = $urandom_range(11, DEFAULT_MAX_ELEMENTS);
            else
                len = $urandom_range(DEFAULT_MAX_ELEMENTS + 1, DEFAULT_MAX_ELEMENTS + 8);
            style = $urandom_range(0, 2);
            set_buf.delete();
            for (int i = 0; i < len; i++)
                set_buf = {set_buf, make_value(style)};
            send_buf();
        end

        s_tvalid <= 1'b0;
        quiet = 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Summary: %0d sets (%0d past capacity), %0d items in, %0d results checked",
                 sets_sent, overflow_sets, items_sent, results_seen);
        $display("Input gaps and output stalls were mixed with unthrottled stretches");
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
